/* src/i2cem_pkg.sv */
// Shared types and constants for the I2C EEPROM master.
package i2cem_pkg;

    localparam int PAGE_BYTES = 16;
    localparam int BUF_IDX_W  = 4;
    localparam int COUNT_W    = 5;

    localparam logic [7:0] RESET_WRITE_ADDR = 8'hA0;
    localparam logic [7:0] RESET_READ_ADDR  = 8'hA1;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_A   = 5'd1,
        PH_CTRLW     = 5'd2,
        PH_CTRLW_ACK = 5'd3,
        PH_ADDR      = 5'd4,
        PH_ADDR_ACK  = 5'd5,
        PH_DATA      = 5'd6,
        PH_DATA_ACK  = 5'd7,
        PH_START_B   = 5'd8,
        PH_CTRLR     = 5'd9,
        PH_CTRLR_ACK = 5'd10,
        PH_RECV      = 5'd11,
        PH_MACK      = 5'd12,
        PH_STOP      = 5'd13
    } phase_t;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_START = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_BYTE_WRITE = 2'd0,
        OP_PAGE_WRITE = 2'd1,
        OP_RAND_READ  = 2'd2,
        OP_SEQ_READ   = 2'd3
    } op_t;

    typedef enum logic {
        CFG_WRITE_ADDR = 1'b0,
        CFG_READ_ADDR  = 1'b1
    } cfg_idx_t;

endpackage

/* src/i2c_eeprom_master_top.sv */
// I2C EEPROM master: half-bit tick phase machine with a registered result word.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | mode operation memory_address data_byte
//          |                        | buffer_index byte_count sda_sample
//  out     | out_valid / out_stall  | scl_level sda_level sda_drive read_valid
//          |                        | read_byte read_last busy_res done_res
//  cfg     | cfg_write              | cfg_index cfg_data
//
// One word in per clock while in_stall is low; its result word appears in the
// output register in the next cycle. Phase and shift registers step per word.
// Reset puts the machine idle, held line levels high, config at 0xA0 / 0xA1.
// in_stall is high only while a result word is held and out_stall is high.
module i2c_eeprom_master_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic [1:0]                      operation,
    input  logic [7:0]                      memory_address,
    input  logic [7:0]                      data_byte,
    input  logic [i2cem_pkg::BUF_IDX_W-1:0] buffer_index,
    input  logic [i2cem_pkg::COUNT_W-1:0]   byte_count,
    input  logic                            sda_sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            scl_level,
    output logic                            sda_level,
    output logic                            sda_drive,
    output logic                            read_valid,
    output logic [7:0]                      read_byte,
    output logic                            read_last,
    output logic                            busy_res,
    output logic                            done_res
);
    import i2cem_pkg::*;

    logic [7:0] write_addr_reg;
    logic [7:0] read_addr_reg;

    phase_t               phase_reg, phase_next;
    logic [1:0]           tick_reg, tick_next;
    logic [2:0]           bitcnt_reg, bitcnt_next;
    logic [COUNT_W-1:0]   bytes_done_reg, bytes_done_next;
    logic [7:0]           shift_reg, shift_next;
    op_t                  cur_op_reg, cur_op_next;
    logic [7:0]           lat_addr_reg, lat_addr_next;
    logic [COUNT_W-1:0]   lat_count_reg, lat_count_next;
    logic [7:0]           lat_data_reg, lat_data_next;
    logic                 held_scl_reg, held_scl_next;
    logic                 held_sda_reg, held_sda_next;
    logic                 held_drive_reg, held_drive_next;

    logic [7:0] page_buf [PAGE_BYTES];

    logic               in_acc;
    logic               tick_active;
    logic               last_byte;
    logic [COUNT_W-1:0] bytes_done_inc;
    logic               rvalid, rlast, done;
    logic [7:0]         rbyte;

    logic       out_valid_reg;
    logic       scl_out_reg, sda_out_reg, drive_out_reg;
    logic       rvalid_out_reg, rlast_out_reg, busy_out_reg, done_out_reg;
    logic [7:0] rbyte_out_reg;

    function automatic logic [7:0] data_for(input op_t op, input logic [COUNT_W-1:0] bd,
                                            input logic [7:0] lat);
        logic [7:0] res;
        res = lat;
        if (op == OP_PAGE_WRITE)
        begin
            if (int'(bd) < PAGE_BYTES)
                res = page_buf[bd[BUF_IDX_W-1:0]];
            else
                res = 8'h00;
        end
        return res;
    endfunction

    assign in_stall       = out_valid_reg && out_stall;
    assign in_acc         = in_valid && !in_stall;
    assign tick_active    = (mode_t'(mode) == MODE_TICK) && (phase_reg != PH_IDLE);
    assign bytes_done_inc = bytes_done_reg + COUNT_W'(1);
    assign last_byte      = ({1'b0, bytes_done_reg} + (COUNT_W+1)'(1))
                            >= {1'b0, lat_count_reg};

    // next state
    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bitcnt_next     = bitcnt_reg;
        bytes_done_next = bytes_done_reg;
        shift_next      = shift_reg;
        cur_op_next     = cur_op_reg;
        lat_addr_next   = lat_addr_reg;
        lat_count_next  = lat_count_reg;
        lat_data_next   = lat_data_reg;
        cnt             = byte_count;
        if (cnt == '0)
            cnt = COUNT_W'(1);
        if (int'(cnt) > PAGE_BYTES)
            cnt = COUNT_W'(PAGE_BYTES);

        if (mode_t'(mode) == MODE_START && phase_reg == PH_IDLE)
        begin
            cur_op_next     = op_t'(operation);
            lat_addr_next   = memory_address;
            lat_data_next   = data_byte;
            lat_count_next  = (op_t'(operation) == OP_PAGE_WRITE ||
                               op_t'(operation) == OP_SEQ_READ) ? cnt : COUNT_W'(1);
            bytes_done_next = '0;
            phase_next      = PH_START_A;
            tick_next       = '0;
            bitcnt_next     = '0;
            shift_next      = '0;
        end
        else if (tick_active)
        begin
            unique case (phase_reg)
                PH_START_A, PH_START_B:
                begin
                    if (tick_reg >= 2'd2)
                    begin
                        tick_next   = '0;
                        bitcnt_next = '0;
                        if (phase_reg == PH_START_A)
                        begin
                            phase_next = PH_CTRLW;
                            shift_next = write_addr_reg;
                        end
                        else
                        begin
                            phase_next = PH_CTRLR;
                            shift_next = read_addr_reg;
                        end
                    end
                    else
                        tick_next = tick_reg + 2'd1;
                end
                PH_CTRLW, PH_ADDR, PH_DATA, PH_CTRLR:
                begin
                    if (tick_reg == 2'd0)
                        tick_next = 2'd1;
                    else
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        tick_next  = '0;
                        if (bitcnt_reg == 3'd7)
                        begin
                            bitcnt_next = '0;
                            unique case (phase_reg)
                                PH_CTRLW: phase_next = PH_CTRLW_ACK;
                                PH_ADDR:  phase_next = PH_ADDR_ACK;
                                PH_DATA:  phase_next = PH_DATA_ACK;
                                default:  phase_next = PH_CTRLR_ACK;
                            endcase
                        end
                        else
                            bitcnt_next = bitcnt_reg + 3'd1;
                    end
                end
                PH_CTRLW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_CTRLR_ACK:
                begin
                    if (tick_reg == 2'd0)
                        tick_next = 2'd1;
                    else
                    begin
                        tick_next   = '0;
                        bitcnt_next = '0;
                        shift_next  = '0;
                        unique case (phase_reg)
                            PH_CTRLW_ACK:
                            begin
                                phase_next = PH_ADDR;
                                shift_next = lat_addr_reg;
                            end
                            PH_ADDR_ACK:
                            begin
                                if (cur_op_reg == OP_BYTE_WRITE || cur_op_reg == OP_PAGE_WRITE)
                                begin
                                    phase_next = PH_DATA;
                                    shift_next = data_for(cur_op_reg, bytes_done_reg,
                                                          lat_data_reg);
                                end
                                else
                                    phase_next = PH_START_B;
                            end
                            PH_DATA_ACK:
                            begin
                                bytes_done_next = bytes_done_inc;
                                if (cur_op_reg == OP_PAGE_WRITE &&
                                    bytes_done_inc < lat_count_reg)
                                begin
                                    phase_next = PH_DATA;
                                    shift_next = data_for(cur_op_reg, bytes_done_inc,
                                                          lat_data_reg);
                                end
                                else
                                    phase_next = PH_STOP;
                            end
                            default:
                                phase_next = PH_RECV;
                        endcase
                    end
                end
                PH_RECV:
                begin
                    if (tick_reg == 2'd0)
                    begin
                        shift_next = {shift_reg[6:0], sda_sample};
                        tick_next  = 2'd1;
                    end
                    else
                    begin
                        tick_next = '0;
                        if (bitcnt_reg == 3'd7)
                        begin
                            bitcnt_next = '0;
                            phase_next  = PH_MACK;
                        end
                        else
                            bitcnt_next = bitcnt_reg + 3'd1;
                    end
                end
                PH_MACK:
                begin
                    if (tick_reg == 2'd0)
                        tick_next = 2'd1;
                    else
                    begin
                        bytes_done_next = bytes_done_inc;
                        tick_next       = '0;
                        bitcnt_next     = '0;
                        shift_next      = '0;
                        phase_next      = (bytes_done_inc < lat_count_reg) ? PH_RECV : PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    if (tick_reg >= 2'd2)
                    begin
                        phase_next  = PH_IDLE;
                        tick_next   = '0;
                        bitcnt_next = '0;
                        shift_next  = '0;
                    end
                    else
                        tick_next = tick_reg + 2'd1;
                end
                default:
                begin
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                    bitcnt_next = '0;
                    shift_next  = '0;
                end
            endcase
        end
    end

    // line levels and result flags
    always_comb
    begin
        held_scl_next   = held_scl_reg;
        held_sda_next   = held_sda_reg;
        held_drive_next = held_drive_reg;
        rvalid          = 1'b0;
        rlast           = 1'b0;
        rbyte           = 8'h00;
        done            = 1'b0;
        if (tick_active)
        begin
            unique case (phase_reg)
                PH_START_A, PH_START_B:
                begin
                    held_drive_next = 1'b1;
                    held_scl_next   = (tick_reg < 2'd2);
                    held_sda_next   = (tick_reg == 2'd0);
                end
                PH_CTRLW, PH_ADDR, PH_DATA, PH_CTRLR:
                begin
                    held_drive_next = 1'b1;
                    held_sda_next   = shift_reg[7];
                    held_scl_next   = (tick_reg == 2'd0);
                end
                PH_CTRLW_ACK, PH_ADDR_ACK, PH_DATA_ACK, PH_CTRLR_ACK:
                begin
                    held_drive_next = 1'b0;
                    held_sda_next   = 1'b1;
                    held_scl_next   = (tick_reg == 2'd0);
                end
                PH_RECV:
                begin
                    held_drive_next = 1'b0;
                    held_sda_next   = 1'b1;
                    held_scl_next   = (tick_reg == 2'd0);
                    if (tick_reg == 2'd0 && bitcnt_reg == 3'd7)
                    begin
                        rvalid = 1'b1;
                        rbyte  = {shift_reg[6:0], sda_sample};
                        rlast  = last_byte;
                    end
                end
                PH_MACK:
                begin
                    held_drive_next = 1'b1;
                    held_sda_next   = last_byte;
                    held_scl_next   = (tick_reg == 2'd0);
                end
                PH_STOP:
                begin
                    held_drive_next = 1'b1;
                    held_scl_next   = (tick_reg != 2'd0);
                    held_sda_next   = (tick_reg >= 2'd2);
                    done            = (tick_reg >= 2'd2);
                end
                default:
                begin
                    held_scl_next   = 1'b1;
                    held_sda_next   = 1'b1;
                    held_drive_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_addr_reg <= RESET_WRITE_ADDR;
            read_addr_reg  <= RESET_READ_ADDR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WRITE_ADDR: write_addr_reg <= cfg_data;
                CFG_READ_ADDR:  read_addr_reg  <= cfg_data;
                default:        write_addr_reg <= write_addr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bitcnt_reg     <= '0;
            bytes_done_reg <= '0;
            shift_reg      <= '0;
            cur_op_reg     <= OP_BYTE_WRITE;
            lat_addr_reg   <= '0;
            lat_count_reg  <= COUNT_W'(1);
            lat_data_reg   <= '0;
            held_scl_reg   <= 1'b1;
            held_sda_reg   <= 1'b1;
            held_drive_reg <= 1'b1;
        end
        else if (in_acc)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bitcnt_reg     <= bitcnt_next;
            bytes_done_reg <= bytes_done_next;
            shift_reg      <= shift_next;
            cur_op_reg     <= cur_op_next;
            lat_addr_reg   <= lat_addr_next;
            lat_count_reg  <= lat_count_next;
            lat_data_reg   <= lat_data_next;
            held_scl_reg   <= held_scl_next;
            held_sda_reg   <= held_sda_next;
            held_drive_reg <= held_drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && mode_t'(mode) == MODE_LOAD && phase_reg == PH_IDLE &&
            int'(buffer_index) < PAGE_BYTES)
            page_buf[buffer_index] <= data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_acc)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            scl_out_reg    <= held_scl_next;
            sda_out_reg    <= held_sda_next;
            drive_out_reg  <= held_drive_next;
            rvalid_out_reg <= rvalid;
            rbyte_out_reg  <= rbyte;
            rlast_out_reg  <= rlast;
            busy_out_reg   <= (phase_next != PH_IDLE);
            done_out_reg   <= done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = scl_out_reg;
    assign sda_level  = sda_out_reg;
    assign sda_drive  = drive_out_reg;
    assign read_valid = rvalid_out_reg;
    assign read_byte  = rbyte_out_reg;
    assign read_last  = rlast_out_reg;
    assign busy_res   = busy_out_reg;
    assign done_res   = done_out_reg;

endmodule
